// ----- design/tpbf_pkg.sv -----
// Shared types and constants for the tile plane block fetch pipeline.
package tpbf_pkg;

    localparam int LayoutAw = 11;
    localparam int ChunkAw  = 15;
    localparam int BankAw   = 10;
    localparam int NumWords = 4;

    localparam logic [15:0] TopDown  = 16'h1000;
    localparam logic [15:0] LeftRight = 16'h0800;
    localparam logic [15:0] StripOff = 16'h0010;

    typedef enum logic [1:0] {
        K_LAYOUT = 2'd0,
        K_CHUNK  = 2'd1,
        K_BLOCK  = 2'd2,
        K_DRAW   = 2'd3
    } t_kind;

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [14:0] address;
        logic [15:0] data;
        logic        layer;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] base;
    } t_pipe;

endpackage

// ----- design/tpbf_layout.sv -----
// Layout stage: layout byte store, chunk number lookup and nametable base address.
module tpbf_layout (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpbf_pkg::t_pipe i_pipe,
    output tpbf_pkg::t_pipe o_pipe,
    output logic [7:0]      o_cnum
);
    import tpbf_pkg::*;

    logic [7:0]         r_layout [2**LayoutAw];
    logic [LayoutAw-1:0] n_rd_addr;
    logic [15:0]        n_base;
    t_pipe              r_pipe;
    logic [7:0]         r_cnum;

    assign n_rd_addr = {i_pipe.layer, i_pipe.ly[10:8], i_pipe.lx[14:8]};
    assign n_base    = i_pipe.base + {4'b0, i_pipe.ly[7:4], 8'b0}
                                   + {9'b0, i_pipe.lx[8:4], 2'b0};

    always_ff @(posedge i_clk) begin
        if (i_pipe.valid && i_pipe.kind == K_LAYOUT) begin
            r_layout[i_pipe.address[LayoutAw-1:0]] <= i_pipe.data[7:0];
        end
        r_cnum <= r_layout[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else begin
            r_pipe.valid <= i_pipe.valid;
        end
        r_pipe.kind    <= i_pipe.kind;
        r_pipe.address <= i_pipe.address;
        r_pipe.data    <= i_pipe.data;
        r_pipe.layer   <= i_pipe.layer;
        r_pipe.lx      <= i_pipe.lx;
        r_pipe.ly      <= i_pipe.ly;
        r_pipe.base    <= n_base;
    end

    assign o_pipe = r_pipe;
    assign o_cnum = r_cnum;

endmodule

// ----- design/tpbf_chunk.sv -----
// Chunk stage: chunk cell word store and cell lookup inside the selected chunk.
module tpbf_chunk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpbf_pkg::t_pipe i_pipe,
    input  logic [7:0]      i_cnum,
    output tpbf_pkg::t_pipe o_pipe,
    output logic [15:0]     o_cell,
    output logic            o_empty
);
    import tpbf_pkg::*;

    logic [15:0]        r_chunk [2**ChunkAw];
    logic [6:0]         n_chunk_sel;
    logic [ChunkAw-1:0] n_rd_addr;
    t_pipe              r_pipe;
    logic [15:0]        r_cell;
    logic               r_empty;

    // Chunk numbers start at one; zero marks an empty chunk.
    assign n_chunk_sel = i_cnum[6:0] - 7'd1;
    assign n_rd_addr   = {n_chunk_sel, i_pipe.ly[7:4], i_pipe.lx[7:4]};

    always_ff @(posedge i_clk) begin
        if (i_pipe.valid && i_pipe.kind == K_CHUNK) begin
            r_chunk[i_pipe.address] <= i_pipe.data;
        end
        r_cell <= r_chunk[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else begin
            r_pipe.valid <= i_pipe.valid;
        end
        r_pipe.kind    <= i_pipe.kind;
        r_pipe.address <= i_pipe.address;
        r_pipe.data    <= i_pipe.data;
        r_pipe.layer   <= i_pipe.layer;
        r_pipe.lx      <= i_pipe.lx;
        r_pipe.ly      <= i_pipe.ly;
        r_pipe.base    <= i_pipe.base;
        r_empty        <= (i_cnum == 8'd0);
    end

    assign o_pipe  = r_pipe;
    assign o_cell  = r_cell;
    assign o_empty = r_empty;

endmodule

// ----- design/tpbf_block.sv -----
// Block stage: four banked tile word stores read in parallel for one block.
module tpbf_block (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpbf_pkg::t_pipe i_pipe,
    input  logic [15:0]     i_cell,
    input  logic            i_empty,
    output logic            o_draw,
    output logic            o_empty,
    output logic [1:0]      o_flip,
    output logic [15:0]     o_base,
    output logic [15:0]     o_word [tpbf_pkg::NumWords]
);
    import tpbf_pkg::*;

    logic        r_draw;
    logic        r_empty;
    logic [1:0]  r_flip;
    logic [15:0] r_base;
    logic [15:0] r_word [NumWords];

    // The low two bits of a block word index pick the bank, so all four words of a
    // block sit at the same bank address.
    for (genvar g = 0; g < NumWords; g++) begin : g_bank
        logic [15:0] r_mem [2**BankAw];

        always_ff @(posedge i_clk) begin
            if (i_pipe.valid && i_pipe.kind == K_BLOCK && i_pipe.address[1:0] == 2'(g)) begin
                r_mem[i_pipe.address[BankAw+1:2]] <= i_pipe.data;
            end
            r_word[g] <= r_mem[i_cell[BankAw-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw <= 1'b0;
        end else begin
            r_draw <= i_pipe.valid && i_pipe.kind == K_DRAW;
        end
        r_empty <= i_empty;
        r_flip  <= {i_cell[12], i_cell[11]};
        r_base  <= i_pipe.base;
    end

    assign o_draw  = r_draw;
    assign o_empty = r_empty;
    assign o_flip  = r_flip;
    assign o_base  = r_base;
    assign o_word  = r_word;

endmodule

// ----- design/tpbf_emit.sv -----
// Result stage: applies the cell flips and sends the words out one per cycle.
module tpbf_emit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_draw,
    input  logic        i_empty,
    input  logic [1:0]  i_flip,
    input  logic [15:0] i_base,
    input  logic [15:0] i_word [tpbf_pkg::NumWords],
    output logic        o_strobe,
    output logic [15:0] o_vram_addr,
    output logic [15:0] o_tile_word,
    output logic        o_write_valid,
    output logic        o_last
);
    import tpbf_pkg::*;

    logic        r_active;
    logic [1:0]  r_cnt;
    logic        r_empty;
    logic [15:0] r_base;
    logic [15:0] r_word [NumWords];
    logic [15:0] n_toggle;
    logic        n_last;

    // A vertical flip swaps rows (index bit 1), a horizontal flip swaps columns
    // (index bit 0); each also toggles its flip bit in every word.
    assign n_toggle = (i_flip[1] ? TopDown : 16'h0) | (i_flip[0] ? LeftRight : 16'h0);
    assign n_last   = r_empty || r_cnt == 2'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= 2'd0;
        end else if (i_draw) begin
            r_active <= 1'b1;
            r_cnt    <= 2'd0;
        end else if (r_active) begin
            r_active <= !n_last;
            r_cnt    <= r_cnt + 2'd1;
        end
        if (i_draw) begin
            r_empty <= i_empty;
            r_base  <= i_base;
            for (int k = 0; k < NumWords; k++) begin
                r_word[k] <= i_word[2'(k) ^ i_flip] ^ n_toggle;
            end
        end
    end

    assign o_strobe      = r_active;
    assign o_vram_addr   = r_base + {8'b0, r_cnt[1], 5'b0, r_cnt[0], 1'b0};
    assign o_tile_word   = r_empty ? 16'h0 : r_word[r_cnt];
    assign o_write_valid = !r_empty;
    assign o_last        = n_last;

endmodule

// ----- design/tile_plane_block_fetch.sv -----
// Top level of the tile plane block fetch: input register and the stage chain.
//
// Items are offered on the i_ payload ports with start held high; an item is
// taken at a rising edge where start is high and busy is low. Load items
// (layout byte, chunk cell word, block tile word) write one store entry and
// give no result. A draw item gives four nametable writes, or a single
// result with o_write_valid low when its chunk is empty.
// Results come out on the o_ payload ports, each valid for exactly one cycle
// while o_strobe is high, with o_last marking the final result of a draw.
// The receiver cannot stall, so results are never held back.
// The first result of a draw passes the input register, layout read,
// chunk read, block read and result register, and the rest follow in
// consecutive cycles.
// A load item can be taken in every cycle while busy is low; after a draw,
// busy holds off further items because the result port sends one word per
// cycle, so the next draw cannot overrun the result stage.
// Writes travel the pipeline with the draws and land in their store at the
// stage that reads it, so every draw sees exactly the writes taken before it.
// A synchronous reset clears the valid bits and busy; the stores keep
// their contents and must be loaded before a draw reads them.
module tile_plane_block_fetch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [14:0] i_address,
    input  logic [15:0] i_data,
    input  logic        i_layer,
    input  logic signed [15:0] i_cam_x,
    input  logic signed [15:0] i_cam_y,
    input  logic [3:0]  i_strip,
    input  logic [4:0]  i_column,
    input  logic [15:0] i_plane_base,
    output logic        o_strobe,
    output logic [15:0] o_vram_addr,
    output logic [15:0] o_tile_word,
    output logic        o_write_valid,
    output logic        o_last
);
    import tpbf_pkg::*;

    logic        n_accept;
    logic [1:0]  r_gap;
    t_pipe       r_in;
    t_pipe       lay_pipe;
    logic [7:0]  lay_cnum;
    t_pipe       chk_pipe;
    logic [15:0] chk_cell;
    logic        chk_empty;
    logic        blk_draw;
    logic        blk_empty;
    logic [1:0]  blk_flip;
    logic [15:0] blk_base;
    logic [15:0] blk_word [NumWords];

    assign n_accept = start && !busy;
    assign busy     = r_gap != 2'd0;

    // Busy spacing after a draw keeps the result stage from being overrun.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= 2'd0;
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= n_accept;
            if (n_accept && t_kind'(i_kind) == K_DRAW) begin
                r_gap <= 2'd3;
            end else if (r_gap != 2'd0) begin
                r_gap <= r_gap - 2'd1;
            end
        end
        // Level position: camera plus the block's screen offset, wrapping at 16 bits.
        r_in.kind    <= t_kind'(i_kind);
        r_in.address <= i_address;
        r_in.data    <= i_data;
        r_in.layer   <= i_layer;
        r_in.lx      <= i_cam_x + {7'b0, i_column, 4'b0};
        r_in.ly      <= i_cam_y + {8'b0, i_strip, 4'b0} - StripOff;
        r_in.base    <= i_plane_base;
    end

    tpbf_layout u_layout (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (r_in),
        .o_pipe  (lay_pipe),
        .o_cnum  (lay_cnum)
    );

    tpbf_chunk u_chunk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (lay_pipe),
        .i_cnum  (lay_cnum),
        .o_pipe  (chk_pipe),
        .o_cell  (chk_cell),
        .o_empty (chk_empty)
    );

    tpbf_block u_block (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (chk_pipe),
        .i_cell  (chk_cell),
        .i_empty (chk_empty),
        .o_draw  (blk_draw),
        .o_empty (blk_empty),
        .o_flip  (blk_flip),
        .o_base  (blk_base),
        .o_word  (blk_word)
    );

    tpbf_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_draw        (blk_draw),
        .i_empty       (blk_empty),
        .i_flip        (blk_flip),
        .i_base        (blk_base),
        .i_word        (blk_word),
        .o_strobe      (o_strobe),
        .o_vram_addr   (o_vram_addr),
        .o_tile_word   (o_tile_word),
        .o_write_valid (o_write_valid),
        .o_last        (o_last)
    );

endmodule
